@@ design/afit_pkg.sv @@
`default_nettype none
package afit_pkg;

   // default word geometry, Q16.16
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   // configuration register indexes
   localparam int CSR_IDX_WIDTH = 3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAT_A = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAT_B = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAT_C = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAT_D = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAT_E = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAT_F = 3'd5;

   // result status codes
   typedef enum logic [1:0] {
      FIT_OK    = 2'd0,
      FIT_EMPTY = 2'd1,
      FIT_DEGEN = 2'd2
   } fit_status_type;

endpackage
`default_nettype wire

@@ design/affine_bbox_fit_matrix.sv @@
// Each accepted req word gives one rsp word; the restoring divider resolves one
// quotient bit per stage; coordinates default to Q16.16.
// Throughput: one word per cycle; the whole pipe holds while rsp is stalled.
// Reset: synchronous, active high; clears all valid bits and loads the identity
// matrix (a = d = 1.0, others 0).
`default_nettype none
module affine_bbox_fit_matrix #(
   parameter int COORD_WIDTH = afit_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = afit_pkg::FRAC_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [afit_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  wire logic [COORD_WIDTH-1:0]             csr_wdata,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [COORD_WIDTH-1:0]             req_box_left,
   input  wire logic [COORD_WIDTH-1:0]             req_box_bottom,
   input  wire logic [COORD_WIDTH-2:0]             req_box_width,
   input  wire logic [COORD_WIDTH-2:0]             req_box_height,
   input  wire logic [COORD_WIDTH-1:0]             req_target_left,
   input  wire logic [COORD_WIDTH-1:0]             req_target_bottom,
   input  wire logic [COORD_WIDTH-2:0]             req_target_width,
   input  wire logic [COORD_WIDTH-2:0]             req_target_height,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [COORD_WIDTH-1:0]                  rsp_scale_x,
   output logic [COORD_WIDTH-1:0]                  rsp_scale_y,
   output logic [COORD_WIDTH-1:0]                  rsp_offset_x,
   output logic [COORD_WIDTH-1:0]                  rsp_offset_y,
   output logic [1:0]                              rsp_fit_status
);
   import afit_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int PW = 2 * W + 1;
   localparam int MW = 2 * W;
   localparam int LW = 2 * W + 4;
   localparam int NB = W - 1 + F;
   localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] ONE  = {{(W-1-F){1'b0}}, 1'b1, {F{1'b0}}};

   // clamp a wide signed value into the word range
   function automatic logic signed [W-1:0] sat_w(input logic signed [LW-1:0] v);
      logic all_ones;
      logic all_zeros;
      all_ones  = &v[LW-1:W-1];
      all_zeros = ~|v[LW-1:W-1];
      if (all_ones || all_zeros) begin
         sat_w = v[W-1:0];
      end else if (v[LW-1]) begin
         sat_w = CMIN;
      end else begin
         sat_w = CMAX;
      end
   endfunction

   // whole pipe moves unless the output word is held
   logic adv;
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // matrix registers
   logic signed [W-1:0] mat_a_ff, mat_b_ff, mat_c_ff, mat_d_ff, mat_e_ff, mat_f_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         mat_a_ff <= ONE;
         mat_b_ff <= '0;
         mat_c_ff <= '0;
         mat_d_ff <= ONE;
         mat_e_ff <= '0;
         mat_f_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAT_A: mat_a_ff <= csr_wdata;
            CSR_MAT_B: mat_b_ff <= csr_wdata;
            CSR_MAT_C: mat_c_ff <= csr_wdata;
            CSR_MAT_D: mat_d_ff <= csr_wdata;
            CSR_MAT_E: mat_e_ff <= csr_wdata;
            CSR_MAT_F: mat_f_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1: box corner coordinates, empty check
   logic                  s1_v_ff;
   logic [W:0]            s1_xs_ff [2];
   logic [W:0]            s1_ys_ff [2];
   logic signed [W-1:0]   s1_org_ff [2];
   logic [W-2:0]          s1_size_ff [2];
   fit_status_type        s1_st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_xs_ff[0]   <= {req_box_left[W-1], req_box_left};
         s1_xs_ff[1]   <= {req_box_left[W-1], req_box_left} + {2'b00, req_box_width};
         s1_ys_ff[0]   <= {req_box_bottom[W-1], req_box_bottom};
         s1_ys_ff[1]   <= {req_box_bottom[W-1], req_box_bottom} + {2'b00, req_box_height};
         s1_org_ff[0]  <= req_target_left;
         s1_org_ff[1]  <= req_target_bottom;
         s1_size_ff[0] <= req_target_width;
         s1_size_ff[1] <= req_target_height;
         s1_st_ff      <= (req_box_width == '0 || req_box_height == '0) ? FIT_EMPTY : FIT_OK;
      end
   end

   // stage 2: partial products
   logic                  s2_v_ff;
   logic signed [PW-1:0]  s2_pa_ff [2];
   logic signed [PW-1:0]  s2_pb_ff [2];
   logic signed [PW-1:0]  s2_pc_ff [2];
   logic signed [PW-1:0]  s2_pd_ff [2];
   logic signed [W-1:0]   s2_org_ff [2];
   logic [W-2:0]          s2_size_ff [2];
   fit_status_type        s2_st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 2; i++) begin
            s2_pa_ff[i]   <= PW'(mat_a_ff) * PW'($signed(s1_xs_ff[i]));
            s2_pb_ff[i]   <= PW'(mat_b_ff) * PW'($signed(s1_xs_ff[i]));
            s2_pc_ff[i]   <= PW'(mat_c_ff) * PW'($signed(s1_ys_ff[i]));
            s2_pd_ff[i]   <= PW'(mat_d_ff) * PW'($signed(s1_ys_ff[i]));
            s2_org_ff[i]  <= s1_org_ff[i];
            s2_size_ff[i] <= s1_size_ff[i];
         end
         s2_st_ff <= s1_st_ff;
      end
   end

   // stage 3: mapped corners, floor shift, clamp
   logic                  s3_v_ff;
   logic signed [W-1:0]   s3_cx_ff [4];
   logic signed [W-1:0]   s3_cy_ff [4];
   logic signed [W-1:0]   s3_cx_in [4];
   logic signed [W-1:0]   s3_cy_in [4];
   logic signed [W-1:0]   s3_org_ff [2];
   logic [W-2:0]          s3_size_ff [2];
   fit_status_type        s3_st_ff;

   always_comb begin
      logic signed [LW-1:0] sum_x;
      logic signed [LW-1:0] sum_y;
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            sum_x = LW'(s2_pa_ff[i]) + LW'(s2_pc_ff[j]) + (LW'(mat_e_ff) <<< F);
            sum_y = LW'(s2_pb_ff[i]) + LW'(s2_pd_ff[j]) + (LW'(mat_f_ff) <<< F);
            s3_cx_in[2*i+j] = sat_w(sum_x >>> F);
            s3_cy_in[2*i+j] = sat_w(sum_y >>> F);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_cx_ff   <= s3_cx_in;
         s3_cy_ff   <= s3_cy_in;
         s3_org_ff  <= s2_org_ff;
         s3_size_ff <= s2_size_ff;
         s3_st_ff   <= s2_st_ff;
      end
   end

   // stage 4: bounds of the mapped corners
   logic                  s4_v_ff;
   logic signed [W-1:0]   s4_lo_ff [2];
   logic signed [W-1:0]   s4_hi_ff [2];
   logic signed [W-1:0]   s4_lo_in [2];
   logic signed [W-1:0]   s4_hi_in [2];
   logic signed [W-1:0]   s4_org_ff [2];
   logic [W-2:0]          s4_size_ff [2];
   fit_status_type        s4_st_ff;

   always_comb begin
      logic signed [W-1:0] lo01, lo23, hi01, hi23;
      logic signed [W-1:0] ylo01, ylo23, yhi01, yhi23;
      lo01  = (s3_cx_ff[1] < s3_cx_ff[0]) ? s3_cx_ff[1] : s3_cx_ff[0];
      lo23  = (s3_cx_ff[3] < s3_cx_ff[2]) ? s3_cx_ff[3] : s3_cx_ff[2];
      hi01  = (s3_cx_ff[1] > s3_cx_ff[0]) ? s3_cx_ff[1] : s3_cx_ff[0];
      hi23  = (s3_cx_ff[3] > s3_cx_ff[2]) ? s3_cx_ff[3] : s3_cx_ff[2];
      ylo01 = (s3_cy_ff[1] < s3_cy_ff[0]) ? s3_cy_ff[1] : s3_cy_ff[0];
      ylo23 = (s3_cy_ff[3] < s3_cy_ff[2]) ? s3_cy_ff[3] : s3_cy_ff[2];
      yhi01 = (s3_cy_ff[1] > s3_cy_ff[0]) ? s3_cy_ff[1] : s3_cy_ff[0];
      yhi23 = (s3_cy_ff[3] > s3_cy_ff[2]) ? s3_cy_ff[3] : s3_cy_ff[2];
      s4_lo_in[0] = (lo23 < lo01) ? lo23 : lo01;
      s4_hi_in[0] = (hi23 > hi01) ? hi23 : hi01;
      s4_lo_in[1] = (ylo23 < ylo01) ? ylo23 : ylo01;
      s4_hi_in[1] = (yhi23 > yhi01) ? yhi23 : yhi01;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (adv) begin
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_lo_ff   <= s4_lo_in;
         s4_hi_ff   <= s4_hi_in;
         s4_org_ff  <= s3_org_ff;
         s4_size_ff <= s3_size_ff;
         s4_st_ff   <= s3_st_ff;
      end
   end

   // divider stage 0: span, degenerate check, numerator load
   logic                  dv_v_ff    [NB+1];
   logic [W-1:0]          dv_span_ff [NB+1][2];
   logic [W-1:0]          dv_rem_ff  [NB+1][2];
   logic [NB-1:0]         dv_num_ff  [NB+1][2];
   logic [NB-1:0]         dv_q_ff    [NB+1][2];
   logic signed [W-1:0]   dv_lo_ff   [NB+1][2];
   logic signed [W-1:0]   dv_org_ff  [NB+1][2];
   fit_status_type        dv_st_ff   [NB+1];

   logic [W-1:0]          span_in [2];
   assign span_in[0] = s4_hi_ff[0] - s4_lo_ff[0];
   assign span_in[1] = s4_hi_ff[1] - s4_lo_ff[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 2; a++) begin
            dv_span_ff[0][a] <= span_in[a];
            dv_rem_ff[0][a]  <= '0;
            dv_num_ff[0][a]  <= {s4_size_ff[a], {F{1'b0}}};
            dv_q_ff[0][a]    <= '0;
            dv_lo_ff[0][a]   <= s4_lo_ff[a];
            dv_org_ff[0][a]  <= s4_org_ff[a];
         end
         if (s4_st_ff == FIT_OK && (span_in[0] == '0 || span_in[1] == '0)) begin
            dv_st_ff[0] <= FIT_DEGEN;
         end else begin
            dv_st_ff[0] <= s4_st_ff;
         end
      end
   end

   // restoring divider, one quotient bit per stage
   for (genvar k = 0; k < NB; k++) begin : g_div
      logic [W-1:0]  rem_in [2];
      logic          qbit_in [2];

      always_comb begin
         logic [W:0] trial;
         logic [W:0] diff;
         for (int a = 0; a < 2; a++) begin
            trial = {dv_rem_ff[k][a], dv_num_ff[k][a][NB-1]};
            diff  = trial - {1'b0, dv_span_ff[k][a]};
            qbit_in[a] = !diff[W];
            rem_in[a]  = diff[W] ? trial[W-1:0] : diff[W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[k+1] <= dv_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int a = 0; a < 2; a++) begin
               dv_span_ff[k+1][a] <= dv_span_ff[k][a];
               dv_rem_ff[k+1][a]  <= rem_in[a];
               dv_num_ff[k+1][a]  <= {dv_num_ff[k][a][NB-2:0], 1'b0};
               dv_q_ff[k+1][a]    <= {dv_q_ff[k][a][NB-2:0], qbit_in[a]};
               dv_lo_ff[k+1][a]   <= dv_lo_ff[k][a];
               dv_org_ff[k+1][a]  <= dv_org_ff[k][a];
            end
            dv_st_ff[k+1] <= dv_st_ff[k];
         end
      end
   end

   // stage 6: clamp quotient to scale
   logic                  s6_v_ff;
   logic signed [W-1:0]   s6_scale_ff [2];
   logic signed [W-1:0]   s6_lo_ff [2];
   logic signed [W-1:0]   s6_org_ff [2];
   fit_status_type        s6_st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
      end else if (adv) begin
         s6_v_ff <= dv_v_ff[NB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 2; a++) begin
            s6_scale_ff[a] <= (|dv_q_ff[NB][a][NB-1:W-1]) ? CMAX : dv_q_ff[NB][a][W-1:0];
            s6_lo_ff[a]    <= dv_lo_ff[NB][a];
            s6_org_ff[a]   <= dv_org_ff[NB][a];
         end
         s6_st_ff <= dv_st_ff[NB];
      end
   end

   // stage 7: low bound times scale
   logic                  s7_v_ff;
   logic signed [MW-1:0]  s7_prod_ff [2];
   logic signed [W-1:0]   s7_scale_ff [2];
   logic signed [W-1:0]   s7_org_ff [2];
   fit_status_type        s7_st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_v_ff <= 1'b0;
      end else if (adv) begin
         s7_v_ff <= s6_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 2; a++) begin
            s7_prod_ff[a]  <= MW'(s6_lo_ff[a]) * MW'(s6_scale_ff[a]);
            s7_scale_ff[a] <= s6_scale_ff[a];
            s7_org_ff[a]   <= s6_org_ff[a];
         end
         s7_st_ff <= s6_st_ff;
      end
   end

   // output word: offsets and status select
   logic signed [W-1:0]   off_in [2];
   logic [W-1:0]          rsp_scale_x_ff, rsp_scale_y_ff;
   logic [W-1:0]          rsp_offset_x_ff, rsp_offset_y_ff;
   fit_status_type        rsp_st_ff;

   always_comb begin
      logic signed [LW-1:0] t;
      for (int a = 0; a < 2; a++) begin
         t = (LW'(s7_org_ff[a]) <<< F) - LW'(s7_prod_ff[a]);
         off_in[a] = sat_w(t >>> F);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s7_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_st_ff <= s7_st_ff;
         unique case (s7_st_ff)
            FIT_OK: begin
               rsp_scale_x_ff  <= s7_scale_ff[0];
               rsp_scale_y_ff  <= s7_scale_ff[1];
               rsp_offset_x_ff <= off_in[0];
               rsp_offset_y_ff <= off_in[1];
            end
            FIT_EMPTY: begin
               rsp_scale_x_ff  <= ONE;
               rsp_scale_y_ff  <= ONE;
               rsp_offset_x_ff <= '0;
               rsp_offset_y_ff <= '0;
            end
            default: begin
               rsp_scale_x_ff  <= '0;
               rsp_scale_y_ff  <= '0;
               rsp_offset_x_ff <= '0;
               rsp_offset_y_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scale_x    = rsp_scale_x_ff;
   assign rsp_scale_y    = rsp_scale_y_ff;
   assign rsp_offset_x   = rsp_offset_x_ff;
   assign rsp_offset_y   = rsp_offset_y_ff;
   assign rsp_fit_status = rsp_st_ff;

   // checks
   a_empty_identity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fit_status == FIT_EMPTY |->
         rsp_scale_x == ONE && rsp_scale_y == ONE &&
         rsp_offset_x == '0 && rsp_offset_y == '0)
      else $error("empty box word is not the identity");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fit_status == FIT_DEGEN |->
         rsp_scale_x == '0 && rsp_scale_y == '0 &&
         rsp_offset_x == '0 && rsp_offset_y == '0)
      else $error("degenerate box word is not all zero");

   a_scale_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fit_status == FIT_OK |->
         !rsp_scale_x[W-1] && !rsp_scale_y[W-1])
      else $error("fitted scale went negative");

endmodule
`default_nettype wire

@@ sim/tb_affine_bbox_fit_matrix.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb_affine_bbox_fit_matrix;
   import afit_pkg::*;

   localparam int CW = 32;
   localparam int FB = 16;
   localparam int LATENCY = CW + FB + 7;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic signed [CW-1:0] ONE = 32'sh0001_0000;
   localparam logic signed [CW-1:0] CMAX = 32'sh7fff_ffff;
   localparam logic signed [CW-1:0] CMIN = 32'sh8000_0000;

   typedef struct packed {
      logic [CW-1:0] box_left;
      logic [CW-1:0] box_bottom;
      logic [CW-2:0] box_width;
      logic [CW-2:0] box_height;
      logic [CW-1:0] target_left;
      logic [CW-1:0] target_bottom;
      logic [CW-2:0] target_width;
      logic [CW-2:0] target_height;
   } box_word_type;

   typedef struct packed {
      logic [CW-1:0] scale_x;
      logic [CW-1:0] scale_y;
      logic [CW-1:0] offset_x;
      logic [CW-1:0] offset_y;
      fit_status_type status;
   } fit_word_type;

   // directed row: word plus optional typed-in expectation
   typedef struct {
      box_word_type word;
      bit           has_fixed;
      fit_word_type fixed;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_WIDTH-1:0] csr_index = CSR_MAT_A;
   logic [CW-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   box_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [CW-1:0] rsp_scale_x, rsp_scale_y, rsp_offset_x, rsp_offset_y;
   logic [1:0] rsp_fit_status;

   affine_bbox_fit_matrix dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_box_left(req_word.box_left), .req_box_bottom(req_word.box_bottom),
      .req_box_width(req_word.box_width), .req_box_height(req_word.box_height),
      .req_target_left(req_word.target_left),
      .req_target_bottom(req_word.target_bottom),
      .req_target_width(req_word.target_width),
      .req_target_height(req_word.target_height),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_scale_x(rsp_scale_x), .rsp_scale_y(rsp_scale_y),
      .rsp_offset_x(rsp_offset_x), .rsp_offset_y(rsp_offset_y),
      .rsp_fit_status(rsp_fit_status)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // predictor copy of the matrix
   logic signed [CW-1:0] mat [6];
   fit_word_type expected_fits [$];
   int failures = 0;
   int idle_cycles = 0;
   bit stall_enable = 1'b1;

   function automatic logic signed [CW-1:0] sat_coord(logic signed [159:0] v);
      if (v > 160'sd2147483647) return CMAX;
      if (v < -160'sd2147483648) return CMIN;
      return v[CW-1:0];
   endfunction

   // a*p0 + b*p1 + t in fixed point, floor shift, saturate
   function automatic logic signed [CW-1:0] map_point(logic signed [CW-1:0] m0,
         logic signed [CW:0] p0, logic signed [CW-1:0] m1, logic signed [CW:0] p1,
         logic signed [CW-1:0] t);
      logic signed [159:0] s;
      s = 160'(m0) * 160'(p0) + 160'(m1) * 160'(p1) + (160'(t) <<< FB);
      return sat_coord(s >>> FB);
   endfunction

   function automatic void fit_one_axis(logic signed [CW-1:0] org, logic [CW-2:0] size,
         logic signed [CW-1:0] lo, logic signed [CW-1:0] hi,
         output logic [CW-1:0] scale, output logic [CW-1:0] offset);
      logic [159:0] num, span;
      logic signed [159:0] q, t;
      logic signed [CW-1:0] sc;
      num = 160'(size) << FB;
      span = 160'(160'(hi) - 160'(lo));
      q = 160'(num / span);
      sc = sat_coord(q);
      t = (160'(org) <<< FB) - 160'(lo) * 160'(sc);
      scale = sc;
      offset = sat_coord(t >>> FB);
   endfunction

   function automatic fit_word_type predict_fit(box_word_type w);
      fit_word_type r;
      logic signed [CW:0] xs [2], ys [2];
      logic signed [CW-1:0] x, y, xmin, xmax, ymin, ymax;
      r = '0;
      if (w.box_width == 0 || w.box_height == 0) begin
         r.scale_x = ONE;
         r.scale_y = ONE;
         r.status = FIT_EMPTY;
         return r;
      end
      xs[0] = 33'(signed'(w.box_left));
      xs[1] = 33'(signed'(w.box_left)) + 33'(w.box_width);
      ys[0] = 33'(signed'(w.box_bottom));
      ys[1] = 33'(signed'(w.box_bottom)) + 33'(w.box_height);
      xmin = CMAX; xmax = CMIN; ymin = CMAX; ymax = CMIN;
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            x = map_point(mat[0], xs[i], mat[2], ys[j], mat[4]);
            y = map_point(mat[1], xs[i], mat[3], ys[j], mat[5]);
            if (x < xmin) xmin = x;
            if (x > xmax) xmax = x;
            if (y < ymin) ymin = y;
            if (y > ymax) ymax = y;
         end
      end
      if (xmax == xmin || ymax == ymin) begin
         r.status = FIT_DEGEN;
         return r;
      end
      fit_one_axis(w.target_left, w.target_width, xmin, xmax, r.scale_x, r.offset_x);
      fit_one_axis(w.target_bottom, w.target_height, ymin, ymax, r.scale_y, r.offset_y);
      r.status = FIT_OK;
      return r;
   endfunction

   // result check
   always @(posedge clock) begin
      fit_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_fits.size() == 0) begin
            $display("%0t unexpected word: expected none, actual %h %h %h %h %0d", $time,
                     rsp_scale_x, rsp_scale_y, rsp_offset_x, rsp_offset_y, rsp_fit_status);
            failures++;
         end else begin
            e = expected_fits.pop_front();
            if (rsp_scale_x !== e.scale_x) begin
               $display("%0t scale_x: expected %h actual %h", $time, e.scale_x, rsp_scale_x);
               failures++;
            end
            if (rsp_scale_y !== e.scale_y) begin
               $display("%0t scale_y: expected %h actual %h", $time, e.scale_y, rsp_scale_y);
               failures++;
            end
            if (rsp_offset_x !== e.offset_x) begin
               $display("%0t offset_x: expected %h actual %h", $time, e.offset_x,
                        rsp_offset_x);
               failures++;
            end
            if (rsp_offset_y !== e.offset_y) begin
               $display("%0t offset_y: expected %h actual %h", $time, e.offset_y,
                        rsp_offset_y);
               failures++;
            end
            if (rsp_fit_status !== e.status) begin
               $display("%0t fit_status: expected %0d actual %0d", $time, e.status,
                        rsp_fit_status);
               failures++;
            end
         end
      end
   end

   // receiver stall pattern: bursty stalls with quiet stretches
   always @(posedge clock) begin
      int phase;
      phase = $urandom_range(0, 99);
      if (!stall_enable || reset) rsp_stall <= 1'b0;
      else if (rsp_stall) rsp_stall <= phase < 60;
      else rsp_stall <= phase < 20;
   end

   // watchdog on handshakes
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic write_matrix(logic [CSR_IDX_WIDTH-1:0] idx, logic [CW-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      mat[idx] = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_matrix(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c,
         logic [CW-1:0] d, logic [CW-1:0] e, logic [CW-1:0] f);
      write_matrix(CSR_MAT_A, a);
      write_matrix(CSR_MAT_B, b);
      write_matrix(CSR_MAT_C, c);
      write_matrix(CSR_MAT_D, d);
      write_matrix(CSR_MAT_E, e);
      write_matrix(CSR_MAT_F, f);
   endtask

   // present one word, hold until accepted
   task automatic send_word(box_word_type w, fit_word_type exp_fit, bit use_fixed);
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      expected_fits.insert(expected_fits.size(), use_fixed ? exp_fit : predict_fit(w));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_fits.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   function automatic logic [CW-1:0] rand_coord;
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return CMAX;
         2: return CMIN;
         default: return 32'($signed($urandom_range(0, 400)) - 200) <<< FB;
      endcase
   endfunction

   function automatic logic [CW-2:0] rand_size;
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 31'($urandom);
         3: return 31'($urandom_range(1, 3));
         default: return 31'($urandom_range(1, 300)) << FB;
      endcase
   endfunction

   function automatic box_word_type rand_word;
      box_word_type w;
      w.box_left = rand_coord();
      w.box_bottom = rand_coord();
      w.box_width = rand_size();
      w.box_height = rand_size();
      w.target_left = rand_coord();
      w.target_bottom = rand_coord();
      w.target_width = rand_size();
      w.target_height = rand_size();
      return w;
   endfunction

   task automatic random_phase(int count);
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 20);
         while (burst > 0 && count > 0) begin
            send_word(rand_word(), '0, 1'b0);
            burst--;
            count--;
         end
         // gap between bursts, sometimes none
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   directed_row_type directed [$];

   task automatic add_row(box_word_type w, bit fixed_exp, fit_word_type f);
      directed_row_type r;
      r.word = w;
      r.has_fixed = fixed_exp;
      r.fixed = f;
      directed.insert(directed.size(), r);
   endtask

   initial begin
      fit_word_type empty_fit, degen_fit;
      box_word_type w;
      mat[0] = ONE; mat[1] = 0; mat[2] = 0; mat[3] = ONE; mat[4] = 0; mat[5] = 0;
      empty_fit = '{ONE, ONE, '0, '0, FIT_EMPTY};
      degen_fit = '{'0, '0, '0, '0, FIT_DEGEN};

      // directed table
      add_row('{0, 0, 0, 0, 0, 0, 0, 0}, 1, empty_fit);
      add_row('{CMAX, CMIN, '1, 0, CMIN, CMAX, '1, '1}, 1, empty_fit);
      add_row('{CMIN, CMAX, 0, '1, 0, 0, '1, '1}, 1, empty_fit);
      add_row('{0, 0, ONE, ONE, 0, 0, ONE, ONE}, 0, '0);
      add_row('{0, 0, 1, 1, 0, 0, '1, '1}, 0, '0);
      add_row('{CMIN, CMIN, '1, '1, CMAX, CMIN, '1, '1}, 0, '0);
      add_row('{CMAX, CMAX, '1, '1, CMIN, CMAX, 1, 1}, 0, '0);
      add_row('{32'hffff_0000, 32'h0002_0000, 31'h0003_0000, 31'h0001_8000,
                32'h0010_0000, 32'hfff0_0000, 31'h0064_0000, 31'h0032_0000}, 0, '0);
      add_row('{CMAX, 0, '1, ONE, 0, CMIN, 0, 0}, 0, '0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_word(directed[i].word, directed[i].fixed,
                                      directed[i].has_fixed);
      drain();

      // zero linear part with a translation: every nonempty box collapses
      load_matrix(0, 0, 0, 0, 32'h0005_0000, CMIN);
      w = '{0, 0, ONE, ONE, 0, 0, ONE, ONE};
      send_word(w, degen_fit, 1'b1);
      w = '{CMIN, CMAX, '1, '1, CMAX, CMIN, '1, '1};
      send_word(w, degen_fit, 1'b1);
      send_word('{0, 0, 0, ONE, 0, 0, ONE, ONE}, empty_fit, 1'b1);
      drain();

      // extreme matrix entries, saturating corners
      load_matrix(CMAX, CMIN, CMIN, CMAX, CMAX, CMIN);
      random_phase(40);
      drain();

      // rotation with scale
      load_matrix(0, 32'h0002_0000, 32'hffff_0000, 0, 32'h0100_0000, 32'hff00_0000);
      random_phase(200);
      drain();

      // random matrices with long runs, some with no stalls at all
      for (int p = 0; p < 4; p++) begin
         stall_enable = (p != 2);
         load_matrix($urandom, $urandom, $urandom_range(0, 1) ? $urandom : 0,
                     $urandom, $urandom, $urandom);
         random_phase(60);
         drain();
         load_matrix(32'($urandom_range(0, 'h40000)) - 32'h20000,
                     32'($urandom_range(0, 'h40000)) - 32'h20000,
                     32'($urandom_range(0, 'h40000)) - 32'h20000,
                     32'($urandom_range(0, 'h40000)) - 32'h20000,
                     32'($urandom_range(0, 'h400000)) - 32'h200000,
                     32'($urandom_range(0, 'h400000)) - 32'h200000);
         random_phase(60);
         drain();
      end
      stall_enable = 1'b1;

      // back to identity
      load_matrix(ONE, 0, 0, ONE, 0, 0);
      random_phase(30);
      drain();

      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
